// File: src/qgtb_pkg.sv
// Package for the quad gated timer block: operation and register codes,
// mode word bit positions and the structs passed between modules.
// No dependencies.
package qgtb_pkg;

  localparam int MAX_TIMERS  = 4;
  localparam int OP_W        = 3;
  localparam int TSEL_W      = 2;
  localparam int RSEL_W      = 2;
  localparam int DATA_W      = 16;
  localparam int PRESCALE_W  = 15;

  // Operation codes
  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
  localparam logic [OP_W-1:0] OP_HBLANK = 3'd2;
  localparam logic [OP_W-1:0] OP_VBLANK = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

  // Register codes
  localparam logic [RSEL_W-1:0] REG_COUNT   = 2'd0;
  localparam logic [RSEL_W-1:0] REG_MODE    = 2'd1;
  localparam logic [RSEL_W-1:0] REG_COMPARE = 2'd2;
  localparam logic [RSEL_W-1:0] REG_HOLD    = 2'd3;

  // Gate modes
  localparam logic [1:0] GATE_PAUSE   = 2'd0;
  localparam logic [1:0] GATE_RISE    = 2'd1;
  localparam logic [1:0] GATE_FALL    = 2'd2;
  localparam logic [1:0] GATE_ANY     = 2'd3;

  // Prescale select codes
  localparam logic [1:0] PSC_2        = 2'd0;
  localparam logic [1:0] PSC_32       = 2'd1;
  localparam logic [1:0] PSC_512      = 2'd2;
  localparam logic [1:0] PSC_LINE     = 2'd3;

  // Mode word bits
  localparam int M_GATE_EN   = 2;
  localparam int M_GATE_TYPE = 3;
  localparam int M_CLR_CMP   = 6;
  localparam int M_ENABLE    = 7;
  localparam int M_CMP_IE    = 8;
  localparam int M_OVF_IE    = 9;
  localparam int M_CMP_FLAG  = 10;
  localparam int M_OVF_FLAG  = 11;

  localparam logic [DATA_W-1:0] MODE_CFG_MASK  = 16'h03ff;
  localparam logic [DATA_W-1:0] MODE_FLAG_MASK = 16'h0c00;
  localparam logic [DATA_W-1:0] MODE_WR_MASK   = 16'hf3ff;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TSEL_W-1:0] timer_sel;
    logic [RSEL_W-1:0] reg_sel;
    logic [DATA_W-1:0] write_data;
    logic              gate_active;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] rd;
    logic              irq;
    logic              hold_hit;
  } tmr_res_t;

endpackage

// File: src/qgtb_in_if.sv
// Request channel: valid/ready handshake carrying one timer block command.
// Depends on qgtb_pkg.
interface qgtb_in_if
  import qgtb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [TSEL_W-1:0] timer_sel;
  logic [RSEL_W-1:0] reg_sel;
  logic [DATA_W-1:0] write_data;
  logic              gate_active;

  modport source (output valid, op, timer_sel, reg_sel, write_data, gate_active,
                  input ready);
  modport sink   (input valid, op, timer_sel, reg_sel, write_data, gate_active,
                  output ready);
endinterface

// File: src/qgtb_out_if.sv
// Response channel: valid/ready handshake carrying read data and interrupts.
// Depends on qgtb_pkg.
interface qgtb_out_if
  import qgtb_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [DATA_W-1:0]     read_data;
  logic [MAX_TIMERS-1:0] timer_irq;
  logic                  hold_irq;

  modport source (output valid, read_data, timer_irq, hold_irq, input ready);
  modport sink   (input valid, read_data, timer_irq, hold_irq, output ready);
endinterface

// File: src/qgtb_timer.sv
// One 16-bit timer: count, mode, compare, optional hold register, prescaler
// and gate state, updated once per accepted command. Depends on qgtb_pkg.
module qgtb_timer
  import qgtb_pkg::*;
#(
  parameter int IDX            = 0,
  parameter int SCANLINE_TICKS = 18740
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     take,
  input  cmd_t     cmd,
  output tmr_res_t res
);

  localparam bit HAS_HOLD = (IDX < 2);

  logic [DATA_W-1:0]     count, count_next;
  logic [DATA_W-1:0]     mode, mode_next;
  logic [DATA_W-1:0]     compare, compare_next;
  logic [DATA_W-1:0]     hold;
  logic [PRESCALE_W-1:0] prescale, prescale_next;
  logic                  gated, gated_next;
  logic                  irq, hold_hit;

  logic                  sel, counting, clr, wrapped, gate_match;
  logic [DATA_W-1:0]     scale, pre_inc, nv;

  assign sel      = (cmd.timer_sel == TSEL_W'(IDX));
  assign counting = mode[M_ENABLE] && !gated;
  assign clr      = mode[M_CLR_CMP];
  assign pre_inc  = {1'b0, prescale} + 16'd1;
  assign gate_match = mode[M_GATE_EN] &&
                      (mode[M_GATE_TYPE] == (cmd.op == OP_VBLANK));

  always_comb begin
    unique case (mode[1:0])
      PSC_2:   scale = 16'd2;
      PSC_32:  scale = 16'd32;
      PSC_512: scale = 16'd512;
      default: scale = DATA_W'(SCANLINE_TICKS);
    endcase
  end

  always_comb begin
    wrapped = 1'b0;
    if (clr && count == compare) begin
      nv = '0;
    end else if (count == 16'hffff) begin
      nv = '0;
      wrapped = 1'b1;
    end else begin
      nv = count + 16'd1;
    end
  end

  always_comb begin
    count_next    = count;
    mode_next     = mode;
    compare_next  = compare;
    prescale_next = prescale;
    gated_next    = gated;
    irq           = 1'b0;
    hold_hit      = 1'b0;
    unique case (cmd.op)
      OP_WRITE: begin
        if (sel) begin
          unique case (cmd.reg_sel)
            REG_COUNT: begin
              if (count != cmd.write_data && counting) prescale_next = '0;
              count_next = cmd.write_data;
            end
            REG_MODE: begin
              if (((cmd.write_data ^ mode) & MODE_CFG_MASK) != '0) begin
                prescale_next = '0;
                gated_next    = 1'b0;
              end
              // flags are write-one-to-clear, never set by a write
              mode_next = (cmd.write_data & MODE_WR_MASK) |
                          (mode & MODE_FLAG_MASK & ~(cmd.write_data & MODE_FLAG_MASK));
            end
            REG_COMPARE: compare_next = cmd.write_data;
            default: ;  // hold register handled below
          endcase
        end
      end
      OP_HBLANK, OP_VBLANK: begin
        if (gate_match) begin
          unique case (mode[5:4])
            GATE_PAUSE: gated_next = cmd.gate_active;
            GATE_RISE, GATE_FALL, GATE_ANY: begin
              if ((mode[5:4] == GATE_ANY) ||
                  (mode[5:4] == GATE_RISE && cmd.gate_active) ||
                  (mode[5:4] == GATE_FALL && !cmd.gate_active)) begin
                if (count != '0 && counting) prescale_next = '0;
                count_next = '0;
              end
            end
            default: ;
          endcase
        end
      end
      OP_TICK: begin
        if (counting) begin
          if (pre_inc < scale) begin
            prescale_next = pre_inc[PRESCALE_W-1:0];
          end else begin
            prescale_next = '0;
            count_next    = nv;
            if (nv == compare && mode[M_CMP_IE] && !mode[M_CMP_FLAG]) begin
              mode_next[M_CMP_FLAG] = 1'b1;
              irq = 1'b1;
            end
            if (wrapped && !clr && mode[M_OVF_IE] && !mode[M_OVF_FLAG]) begin
              mode_next[M_OVF_FLAG] = 1'b1;
              irq = 1'b1;
            end
            hold_hit = HAS_HOLD && (nv == hold);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      mode     <= '0;
      compare  <= '0;
      prescale <= '0;
      gated    <= 1'b0;
    end else if (take) begin
      count    <= count_next;
      mode     <= mode_next;
      compare  <= compare_next;
      prescale <= prescale_next;
      gated    <= gated_next;
    end
  end

  generate
    if (HAS_HOLD) begin : g_hold
      always_ff @(posedge clk) begin
        if (rst) begin
          hold <= '0;
        end else if (take && sel && cmd.op == OP_WRITE && cmd.reg_sel == REG_HOLD) begin
          hold <= cmd.write_data;
        end
      end
    end else begin : g_no_hold
      assign hold = '0;
    end
  endgenerate

  always_comb begin
    res.irq      = irq;
    res.hold_hit = hold_hit;
    unique case (cmd.reg_sel)
      REG_COUNT:   res.rd = count;
      REG_MODE:    res.rd = mode;
      REG_COMPARE: res.rd = compare;
      default:     res.rd = hold;
    endcase
  end

endmodule

// File: src/quad_gated_timer_block_core.sv
// Top level of the quad gated timer block: timer instances, read mux and
// result register. Depends on qgtb_pkg, qgtb_in_if, qgtb_out_if, qgtb_timer.
//
//   channel    dir  payload
//   request    in   op, timer_sel, reg_sel, write_data, gate_active
//   response   out  read_data, timer_irq, hold_irq
//
// One command per cycle unless the response stalls; its response appears in
// the result register the cycle after the transfer, one response per command.
// Timer state updates at the request transfer edge from short logic.
// Synchronous active-high reset clears all timer registers and the result
// valid. A stalled response holds; request ready stays high while the
// result register is empty or being drained in the same cycle.
module quad_gated_timer_block_core
  import qgtb_pkg::*;
#(
  parameter int NUM_TIMERS     = 4,
  parameter int SCANLINE_TICKS = 18740
) (
  input logic        clk,
  input logic        rst,
  qgtb_in_if.sink    request,
  qgtb_out_if.source response
);

  logic                  take;
  cmd_t                  cmd;
  tmr_res_t              res [MAX_TIMERS];
  logic [MAX_TIMERS-1:0] irq_vec;
  logic [MAX_TIMERS-1:0] hold_vec;
  logic                  out_valid;
  logic [DATA_W-1:0]     read_data;
  logic [MAX_TIMERS-1:0] timer_irq;
  logic                  hold_irq;

  assign request.ready = !out_valid || response.ready;
  assign take          = request.valid && request.ready;

  assign cmd.op          = request.op;
  assign cmd.timer_sel   = request.timer_sel;
  assign cmd.reg_sel     = request.reg_sel;
  assign cmd.write_data  = request.write_data;
  assign cmd.gate_active = request.gate_active;

  generate
    for (genvar t = 0; t < MAX_TIMERS; t++) begin : g_tmr
      if (t < NUM_TIMERS) begin : g_on
        qgtb_timer #(
          .IDX            (t),
          .SCANLINE_TICKS (SCANLINE_TICKS)
        ) u_timer (
          .clk  (clk),
          .rst  (rst),
          .take (take),
          .cmd  (cmd),
          .res  (res[t])
        );
      end else begin : g_off
        assign res[t] = '0;
      end
      assign irq_vec[t]  = res[t].irq;
      assign hold_vec[t] = res[t].hold_hit;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      read_data <= (cmd.op == OP_READ) ? res[cmd.timer_sel].rd : '0;
      timer_irq <= irq_vec;
      hold_irq  <= |hold_vec;
    end
  end

  assign response.valid     = out_valid;
  assign response.read_data = read_data;
  assign response.timer_irq = timer_irq;
  assign response.hold_irq  = hold_irq;

endmodule
